[src/lfpd_pkg.sv]
// Shared types and constants for the line-follow PID motor drive block.
package lfpd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int FACTOR_W   = 16;
  localparam int DIGIT_W    = 4;
  localparam int SCAN_PRODW = SAMPLE_W + FACTOR_W;
  localparam int SCAN_ERRW  = 20;
  localparam int ERR_W      = 18;
  localparam int INTEG_W    = 21;
  localparam int DERIV_W    = 19;
  localparam int GAIN_W     = 32;
  localparam int BASE_W     = 16;
  localparam int OPND_W     = 24;
  localparam int MAC_PRODW  = GAIN_W + OPND_W;
  localparam int QSUM_W     = 58;
  localparam int FRAC_W     = 16;
  localparam int DUTY_W     = 11;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int SIDE_MAX   = 4;

  localparam logic signed [ERR_W-1:0]   ERR_MAX   = 18'sd131071;
  localparam logic signed [ERR_W-1:0]   ERR_MIN   = -18'sd131072;
  localparam logic signed [INTEG_W:0]   INTEG_MAX = 22'sd1000000;
  localparam logic signed [INTEG_W:0]   INTEG_MIN = -22'sd1000000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DRIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEFT  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SAT,
    ST_MUL,
    ST_DRIVE
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right_s0;
    logic [SAMPLE_W-1:0] right_s1;
    logic [SAMPLE_W-1:0] right_s2;
    logic [SAMPLE_W-1:0] right_s3;
    logic [SAMPLE_W-1:0] left_s0;
    logic [SAMPLE_W-1:0] left_s1;
    logic [SAMPLE_W-1:0] left_s2;
    logic [SAMPLE_W-1:0] left_s3;
  } in_t;

  typedef struct packed {
    logic              left_forward;
    logic [DUTY_W-1:0] left_duty;
    logic              right_forward;
    logic [DUTY_W-1:0] right_duty;
  } out_t;

endpackage

[src/line_follow_pid_motor_drive.sv]
// Top level: line sensor error, PID step and differential wheel drive.
//
// One sensor scan yields one wheel-drive result. An accepted request runs these
// steps before its result is registered: the scan scales the eight samples one
// 4-bit nibble at a time through a 16x4 multiplier and hands the error on, three
// products (P, I, D) pass in turn through one shared 32x4 digit multiplier (the
// first starts in the cycle that saturates the error and updates the integral),
// the last product is added and both duties are clamped into the output register
// (once an earlier result there is taken). The block works on one request at a
// time and takes the next one in the cycle after the result is loaded into the
// output register, taken or not. Configuration writes take effect at once and are
// to be made only while the block is idle; the block itself does not enforce it.
module line_follow_pid_motor_drive #(
  parameter int SENSORS_PER_SIDE = 4,
  parameter int DUTY_LIMIT       = 2000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lfpd_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lfpd_pkg::out_t                    out_data,
  input  logic                              cfg_write,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfpd_pkg::CFG_W-1:0]        cfg_data
);

  localparam longint LIM_Q = longint'(DUTY_LIMIT) <<< lfpd_pkg::FRAC_W;
  localparam logic signed [lfpd_pkg::QSUM_W-1:0] DUTY_LIM_Q = lfpd_pkg::QSUM_W'(LIM_Q);

  // Configuration registers
  logic signed [lfpd_pkg::GAIN_W-1:0] gain_p;
  logic signed [lfpd_pkg::GAIN_W-1:0] gain_i;
  logic signed [lfpd_pkg::GAIN_W-1:0] gain_d_per_tick;
  logic signed [lfpd_pkg::BASE_W-1:0] base_drive;
  logic [lfpd_pkg::CFG_W-1:0]         scale_right;
  logic [lfpd_pkg::CFG_W-1:0]         scale_left;

  lfpd_pkg::state_t state, state_next;

  logic signed [lfpd_pkg::INTEG_W-1:0] error_integral;
  logic signed [lfpd_pkg::ERR_W-1:0]   last_error;
  logic signed [lfpd_pkg::DERIV_W-1:0] deriv;
  logic signed [lfpd_pkg::QSUM_W-1:0]  qsum;
  logic [1:0]                          op;

  logic                                  scan_start;
  logic                                  scan_done;
  logic signed [lfpd_pkg::SCAN_ERRW-1:0] err_raw;
  logic                                  mac_start;
  logic                                  mac_done;
  logic signed [lfpd_pkg::GAIN_W-1:0]    mac_gain;
  logic signed [lfpd_pkg::OPND_W-1:0]    mac_opnd;
  logic signed [lfpd_pkg::MAC_PRODW-1:0] mac_prod;
  logic                                  out_load;

  logic signed [lfpd_pkg::ERR_W-1:0]   err_sat;
  logic signed [lfpd_pkg::INTEG_W:0]   integ_sum;
  logic signed [lfpd_pkg::INTEG_W-1:0] integ_sat;
  logic signed [lfpd_pkg::QSUM_W-1:0]  base_q;
  logic signed [lfpd_pkg::QSUM_W-1:0]  duty_l;
  logic signed [lfpd_pkg::QSUM_W-1:0]  duty_r;
  logic [lfpd_pkg::DUTY_W:0]           drv_l;
  logic [lfpd_pkg::DUTY_W:0]           drv_r;

  // Clamp a Q42.16 duty and split it into direction and integer magnitude
  function automatic logic [lfpd_pkg::DUTY_W:0] drive_f(
    input logic signed [lfpd_pkg::QSUM_W-1:0] q
  );
    logic signed [lfpd_pkg::QSUM_W-1:0] c;
    logic signed [lfpd_pkg::QSUM_W-1:0] a;
    c = q;
    if (q > DUTY_LIM_Q) c = DUTY_LIM_Q;
    if (q < -DUTY_LIM_Q) c = -DUTY_LIM_Q;
    a = c[lfpd_pkg::QSUM_W-1] ? -c : c;
    return {~c[lfpd_pkg::QSUM_W-1],
            a[lfpd_pkg::FRAC_W +: lfpd_pkg::DUTY_W]};
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d_per_tick <= '0;
      base_drive      <= '0;
      scale_right     <= '0;
      scale_left      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lfpd_pkg::CFG_GAIN_P:      gain_p          <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_GAIN_I:      gain_i          <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_GAIN_D:      gain_d_per_tick <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_BASE_DRIVE:  base_drive      <= cfg_data[lfpd_pkg::BASE_W-1:0];
        lfpd_pkg::CFG_SCALE_RIGHT: scale_right     <= cfg_data;
        lfpd_pkg::CFG_SCALE_LEFT:  scale_left      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sensor scaling
  lfpd_scan #(
    .SENSORS_PER_SIDE(SENSORS_PER_SIDE)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .samples    (in_data),
    .scale_right(scale_right),
    .scale_left (scale_left),
    .done       (scan_done),
    .err_raw    (err_raw)
  );

  // Error saturation and integral update
  always_comb begin
    if (err_raw > lfpd_pkg::SCAN_ERRW'(lfpd_pkg::ERR_MAX)) begin
      err_sat = lfpd_pkg::ERR_MAX;
    end else if (err_raw < lfpd_pkg::SCAN_ERRW'(lfpd_pkg::ERR_MIN)) begin
      err_sat = lfpd_pkg::ERR_MIN;
    end else begin
      err_sat = err_raw[lfpd_pkg::ERR_W-1:0];
    end
    integ_sum = (lfpd_pkg::INTEG_W+1)'(error_integral) + (lfpd_pkg::INTEG_W+1)'(err_sat);
    if (integ_sum > lfpd_pkg::INTEG_MAX) begin
      integ_sat = lfpd_pkg::INTEG_W'(lfpd_pkg::INTEG_MAX);
    end else if (integ_sum < lfpd_pkg::INTEG_MIN) begin
      integ_sat = lfpd_pkg::INTEG_W'(lfpd_pkg::INTEG_MIN);
    end else begin
      integ_sat = integ_sum[lfpd_pkg::INTEG_W-1:0];
    end
  end

  // Multiplier operands: gain follows the running product, the operand is
  // loaded at start for the next one (fresh error, new integral, difference)
  always_comb begin
    case (op)
      2'd0:    mac_gain = gain_p;
      2'd1:    mac_gain = gain_i;
      default: mac_gain = gain_d_per_tick;
    endcase
    if (state == lfpd_pkg::ST_SAT) begin
      mac_gain = gain_p;
      mac_opnd = lfpd_pkg::OPND_W'(err_sat);
    end else if (op == 2'd0) begin
      mac_opnd = lfpd_pkg::OPND_W'(error_integral);
    end else begin
      mac_opnd = lfpd_pkg::OPND_W'(deriv);
    end
  end

  lfpd_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .mcand (mac_gain),
    .mplier(mac_opnd),
    .done  (mac_done),
    .prod  (mac_prod)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lfpd_pkg::ST_IDLE:  if (in_valid) state_next = lfpd_pkg::ST_SCAN;
      lfpd_pkg::ST_SCAN:  if (scan_done) state_next = lfpd_pkg::ST_SAT;
      lfpd_pkg::ST_SAT:   state_next = lfpd_pkg::ST_MUL;
      lfpd_pkg::ST_MUL:   if (mac_done && op == 2'd2) state_next = lfpd_pkg::ST_DRIVE;
      lfpd_pkg::ST_DRIVE: if (!out_valid || out_ready) state_next = lfpd_pkg::ST_IDLE;
      default:            state_next = lfpd_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready   = (state == lfpd_pkg::ST_IDLE);
    scan_start = (state == lfpd_pkg::ST_IDLE) && in_valid;
    mac_start  = (state == lfpd_pkg::ST_SAT)
              || ((state == lfpd_pkg::ST_MUL) && mac_done && (op != 2'd2));
    out_load   = (state == lfpd_pkg::ST_DRIVE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // PID state and product accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      last_error     <= '0;
      op             <= '0;
    end else if (state == lfpd_pkg::ST_SAT) begin
      error_integral <= integ_sat;
      last_error     <= err_sat;
      deriv          <= lfpd_pkg::DERIV_W'(err_sat) - lfpd_pkg::DERIV_W'(last_error);
      qsum           <= '0;
      op             <= '0;
    end else if (state == lfpd_pkg::ST_MUL && mac_done) begin
      qsum <= qsum + lfpd_pkg::QSUM_W'(mac_prod);
      op   <= op + 2'd1;
    end
  end

  // Wheel duties
  assign base_q = lfpd_pkg::QSUM_W'(base_drive) <<< lfpd_pkg::FRAC_W;
  assign duty_l = qsum - base_q;
  assign duty_r = -base_q - qsum;
  assign drv_l  = drive_f(duty_l);
  assign drv_r  = drive_f(duty_r);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid              <= 1'b1;
        out_data.left_forward  <= drv_l[lfpd_pkg::DUTY_W];
        out_data.left_duty     <= drv_l[lfpd_pkg::DUTY_W-1:0];
        out_data.right_forward <= drv_r[lfpd_pkg::DUTY_W];
        out_data.right_duty    <= drv_r[lfpd_pkg::DUTY_W-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/lfpd_scan.sv]
// Digit-serial sensor scaler: sums scaled left samples minus scaled right samples.
module lfpd_scan #(
  parameter int SENSORS_PER_SIDE = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  lfpd_pkg::in_t                        samples,
  input  logic [lfpd_pkg::CFG_W-1:0]           scale_right,
  input  logic [lfpd_pkg::CFG_W-1:0]           scale_left,
  output logic                                 done,
  output logic signed [lfpd_pkg::SCAN_ERRW-1:0] err_raw
);

  localparam int SR_W = $bits(lfpd_pkg::in_t);

  logic                                   busy;
  logic [SR_W-1:0]                        sr;
  logic [2:0]                             idx;
  logic [1:0]                             dig;
  logic [lfpd_pkg::SCAN_PRODW-1:0]        prod;
  logic signed [lfpd_pkg::SCAN_ERRW-1:0]  acc;

  logic [1:0]                             side_pos;
  logic [lfpd_pkg::FACTOR_W-1:0]          factor_raw;
  logic [lfpd_pkg::FACTOR_W-1:0]          factor;
  logic [lfpd_pkg::DIGIT_W-1:0]           digit;
  logic [lfpd_pkg::FACTOR_W+lfpd_pkg::DIGIT_W-1:0] pp;
  logic [lfpd_pkg::SCAN_PRODW-1:0]        prod_next;
  logic signed [lfpd_pkg::SCAN_ERRW-1:0]  term;
  logic signed [lfpd_pkg::SCAN_ERRW-1:0]  acc_next;
  logic                                   last_dig;
  logic                                   last_sensor;

  // Factor for the current sensor; unused sensors contribute nothing
  assign side_pos   = idx[1:0];
  assign factor_raw = idx[2] ? scale_left[{side_pos, 4'b0} +: lfpd_pkg::FACTOR_W]
                             : scale_right[{side_pos, 4'b0} +: lfpd_pkg::FACTOR_W];
  assign factor     = (int'(side_pos) < SENSORS_PER_SIDE) ? factor_raw : '0;

  // One sample nibble per cycle, MSB first
  assign digit     = sr[SR_W-1 -: lfpd_pkg::DIGIT_W];
  assign pp        = 20'(factor) * 20'(digit);
  assign prod_next = {prod[lfpd_pkg::SCAN_PRODW-lfpd_pkg::DIGIT_W-1:0], 4'b0}
                   + lfpd_pkg::SCAN_PRODW'(pp);
  assign term      = $signed({4'b0, prod_next[lfpd_pkg::SCAN_PRODW-1:12]});
  assign acc_next  = idx[2] ? acc + term : acc - term;
  assign last_dig    = (dig == 2'd2);
  assign last_sensor = (idx == 3'd7);

  assign err_raw = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sr   <= samples;
        idx  <= '0;
        dig  <= '0;
        prod <= '0;
        acc  <= '0;
      end else if (busy) begin
        sr <= sr << lfpd_pkg::DIGIT_W;
        if (last_dig) begin
          prod <= '0;
          acc  <= acc_next;
          dig  <= '0;
          if (last_sensor) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            idx <= idx + 3'd1;
          end
        end else begin
          dig  <= dig + 2'd1;
          prod <= prod_next;
        end
      end
    end
  end

endmodule

[src/lfpd_mac.sv]
// Digit-serial signed multiplier: 32-bit gain times 24-bit operand, 4 bits a cycle.
module lfpd_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [lfpd_pkg::GAIN_W-1:0]    mcand,
  input  logic signed [lfpd_pkg::OPND_W-1:0]    mplier,
  output logic                                  done,
  output logic signed [lfpd_pkg::MAC_PRODW-1:0] prod
);

  localparam int PP_W = lfpd_pkg::GAIN_W + lfpd_pkg::DIGIT_W + 1;

  logic                         busy;
  logic                         first;
  logic [2:0]                   cnt;
  logic [lfpd_pkg::OPND_W-1:0]  sr;

  logic [lfpd_pkg::DIGIT_W-1:0]        digit;
  logic signed [lfpd_pkg::DIGIT_W:0]   dig_s;
  logic signed [PP_W-1:0]              mcand_x;
  logic signed [PP_W-1:0]              dig_x;
  logic signed [PP_W-1:0]              pp;
  logic signed [lfpd_pkg::MAC_PRODW-1:0] prod_next;

  // Horner form, MSB digit first; only the top digit carries sign
  assign digit     = sr[lfpd_pkg::OPND_W-1 -: lfpd_pkg::DIGIT_W];
  assign dig_s     = first ? $signed({digit[3], digit}) : $signed({1'b0, digit});
  assign mcand_x   = PP_W'(mcand);
  assign dig_x     = PP_W'(dig_s);
  assign pp        = mcand_x * dig_x;
  assign prod_next = (first ? '0 : (prod <<< lfpd_pkg::DIGIT_W))
                   + lfpd_pkg::MAC_PRODW'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= '0;
        sr    <= mplier;
      end else if (busy) begin
        first <= 1'b0;
        sr    <= sr << lfpd_pkg::DIGIT_W;
        prod  <= prod_next;
        cnt   <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/lfpd_check.sv]
// Port-level checks for the line-follow PID motor drive block.
module lfpd_check #(
  parameter int DUTY_LIMIT = 2000
) (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lfpd_pkg::out_t out_data
);

  localparam int MAG_MAX = (DUTY_LIMIT > 2047) ? 2047 : DUTY_LIMIT;

  // A result waiting on the output holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // Duty magnitudes never pass the clamp
  a_duty_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(out_data.left_duty) <= MAG_MAX)
               && (int'(out_data.right_duty) <= MAG_MAX))
    else $error("duty beyond limit");

  // One scan at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while a scan is in work");

  // No result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind line_follow_pid_motor_drive lfpd_check #(.DUTY_LIMIT(DUTY_LIMIT)) u_check (.*);
